FILE: sv/ula_pkg.sv
// Shared types and constants for the ultrasonic level alarm core.
// Used by the parser, grader and top level; no dependencies.
`timescale 1ns / 1ps

package ula_pkg;

  localparam logic [7:0]  HEADER_BYTE = 8'hFF;
  localparam logic [16:0] MAX17       = 17'h1FFFF;
  localparam logic [15:0] MAX16       = 16'hFFFF;

  // Configuration register indexes
  localparam logic [2:0] CFG_WARNING  = 3'd0;
  localparam logic [2:0] CFG_DANGER   = 3'd1;
  localparam logic [2:0] CFG_CRITICAL = 3'd2;
  localparam logic [2:0] CFG_STARTUP  = 3'd3;
  localparam logic [2:0] CFG_CONFIRM  = 3'd4;
  localparam logic [2:0] CFG_LATCH    = 3'd5;

  typedef enum logic [2:0] {
    STAGE_STARTUP  = 3'd0,
    STAGE_NORMAL   = 3'd1,
    STAGE_WARNING  = 3'd2,
    STAGE_DANGER   = 3'd3,
    STAGE_CRITICAL = 3'd4,
    STAGE_LATCHED  = 3'd5
  } stage_t;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  typedef struct packed {
    logic [15:0] warning_level_mm;
    logic [15:0] danger_level_mm;
    logic [15:0] critical_level_mm;
    logic [15:0] startup_hold_ms;
    logic [15:0] confirm_time_ms;
    logic [16:0] latch_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic frame_good;
    logic frame_bad;
  } parse_res_t;

endpackage

FILE: sv/ula_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ula_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/ula_parser.sv
// Sensor frame parser, sample ring and moving average.
// Depends on ula_pkg and ula_ram.
`timescale 1ns / 1ps

module ula_parser #(
  parameter int SAMPLE_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_en,
  input  logic [7:0]          byte_value,
  output ula_pkg::parse_res_t res,
  output logic [15:0]         average_nxt
);

  import ula_pkg::*;

  localparam int SLOT_W   = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int TOTAL_W  = 16 + $clog2(SAMPLE_COUNT);
  localparam int SHIFT    = TOTAL_W + $clog2(SAMPLE_COUNT);
  localparam int RECIP_W  = SHIFT + 1;
  localparam int PROD_W   = TOTAL_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SAMPLE_COUNT - 1);

  phase_t              phase_r, phase_nxt;
  logic [7:0]          high_r, high_nxt;
  logic [7:0]          low_r, low_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic                wrapped_r, wrapped_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [TOTAL_W-1:0]  cand_r, cand_nxt;
  logic [15:0]         avg_r;
  logic [7:0]          chk;
  logic [15:0]         old_sample;
  logic [15:0]         rd_data;
  logic [PROD_W-1:0]   prod;
  logic                good;

  ula_ram #(
    .WIDTH (16),
    .DEPTH (SAMPLE_COUNT)
  ) u_ring (
    .clk     (clk),
    .wr_en   (good),
    .wr_addr (slot_r),
    .wr_data ({high_r, low_r}),
    .rd_addr (slot_r),
    .rd_data (rd_data)
  );

  // Slots at and past the write pointer are unwritten until the first wrap: read them as zero
  assign old_sample = wrapped_r ? rd_data : 16'd0;
  assign chk        = HEADER_BYTE + high_r + low_r;
  assign prod       = PROD_W'(cand_r) * PROD_W'(RECIP);
  assign good       = byte_en && (phase_r == PH_CHECK) && (chk == byte_value);

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    if (byte_en) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (byte_value == HEADER_BYTE) phase_nxt = PH_HIGH;
        end
        PH_HIGH:  phase_nxt = PH_LOW;
        PH_LOW:   phase_nxt = PH_CHECK;
        PH_CHECK: phase_nxt = PH_HUNT;
      endcase
    end
  end

  // Outputs and datapath
  always_comb begin
    high_nxt       = high_r;
    low_nxt        = low_r;
    cand_nxt       = cand_r;
    total_nxt      = total_r;
    slot_nxt       = slot_r;
    wrapped_nxt    = wrapped_r;
    average_nxt    = avg_r;
    res.frame_good = good;
    res.frame_bad  = byte_en && (phase_r == PH_CHECK) && (chk != byte_value);
    if (byte_en && phase_r == PH_HIGH) begin
      high_nxt = byte_value;
    end
    if (byte_en && phase_r == PH_LOW) begin
      low_nxt  = byte_value;
      // Prepare the new running total ahead of the checksum byte
      cand_nxt = total_r - TOTAL_W'(old_sample) + TOTAL_W'({high_r, byte_value});
    end
    if (good) begin
      total_nxt   = cand_r;
      average_nxt = prod[SHIFT +: 16];
      if (slot_r == LAST_SLOT) begin
        slot_nxt    = '0;
        wrapped_nxt = 1'b1;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      high_r    <= '0;
      low_r     <= '0;
      slot_r    <= '0;
      wrapped_r <= 1'b0;
      total_r   <= '0;
      avg_r     <= '0;
    end else begin
      phase_r   <= phase_nxt;
      high_r    <= high_nxt;
      low_r     <= low_nxt;
      slot_r    <= slot_nxt;
      wrapped_r <= wrapped_nxt;
      total_r   <= total_nxt;
      avg_r     <= average_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

endmodule

FILE: sv/ula_grader.sv
// Tick-driven startup hold, threshold grading and stage-five latch timers.
// Depends on ula_pkg.
`timescale 1ns / 1ps

module ula_grader (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick,
  input  logic [15:0]      average,
  input  ula_pkg::cfg_t    cfg,
  output ula_pkg::stage_t  stage_nxt
);

  import ula_pkg::*;

  logic [16:0] startup_r, startup_nxt;
  logic        below_act_r, below_act_nxt;
  logic [15:0] below_r, below_nxt;
  logic        latch_act_r, latch_act_nxt;
  logic [16:0] latch_r, latch_nxt;
  stage_t      stage_r;
  logic        held;

  always_comb begin
    startup_nxt   = startup_r;
    below_act_nxt = below_act_r;
    below_nxt     = below_r;
    latch_act_nxt = latch_act_r;
    latch_nxt     = latch_r;
    stage_nxt     = stage_r;
    held          = 1'b0;
    if (tick) begin
      if (startup_r != MAX17) startup_nxt = startup_r + 17'd1;
      if (startup_nxt <= {1'b0, cfg.startup_hold_ms}) begin
        stage_nxt = STAGE_STARTUP;
      end else begin
        if (latch_act_r && latch_r != MAX17) latch_nxt = latch_r + 17'd1;
        if (average < cfg.critical_level_mm) begin
          if (!below_act_r) begin
            below_act_nxt = 1'b1;
            below_nxt     = '0;
          end else begin
            if (below_r != MAX16) below_nxt = below_r + 16'd1;
            if (below_nxt >= cfg.confirm_time_ms && !latch_act_r) begin
              latch_act_nxt = 1'b1;
              latch_nxt     = '0;
            end
          end
        end else begin
          below_act_nxt = 1'b0;
        end
        if (latch_act_nxt) begin
          if (latch_nxt < cfg.latch_hold_ms) begin
            held = 1'b1;
          end else begin
            // Hold time over: release and grade normally on this tick
            latch_act_nxt = 1'b0;
            below_act_nxt = 1'b0;
          end
        end
        priority if (held) begin
          stage_nxt = STAGE_LATCHED;
        end else if (average >= cfg.warning_level_mm) begin
          stage_nxt = STAGE_NORMAL;
        end else if (average >= cfg.danger_level_mm) begin
          stage_nxt = STAGE_WARNING;
        end else if (average >= cfg.critical_level_mm) begin
          stage_nxt = STAGE_DANGER;
        end else begin
          stage_nxt = STAGE_CRITICAL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      startup_r   <= '0;
      below_act_r <= 1'b0;
      below_r     <= '0;
      latch_act_r <= 1'b0;
      latch_r     <= '0;
      stage_r     <= STAGE_STARTUP;
    end else begin
      startup_r   <= startup_nxt;
      below_act_r <= below_act_nxt;
      below_r     <= below_nxt;
      latch_act_r <= latch_act_nxt;
      latch_r     <= latch_nxt;
      stage_r     <= stage_nxt;
    end
  end

endmodule

FILE: sv/ultrasonic_level_alarm_core.sv
// Top level of the ultrasonic level alarm: input register, configuration,
// frame parser and grader, result register. Depends on ula_pkg and all ula_ modules.
`timescale 1ns / 1ps

// One item (sensor byte or millisecond tick) is taken every clock cycle while
// the result register is free or being taken. Each item is held in the input
// register, then the parse/grade logic writes its result into the result
// register. The result register frees as it is taken, so a full rate
// stream flows with out_tready held high. Every item yields exactly one
// result. The sample ring holds SAMPLE_COUNT entries in a small RAM; no
// clearing pass is needed after reset, since slots not yet written since
// reset read as zero. The average is the ring total times a reciprocal
// constant, one multiply between the running-total register and the result
// register.
module ultrasonic_level_alarm_core #(
  parameter int SAMPLE_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tuser,   // [0] kind (0 byte, 1 tick)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [2:0] stage, [3] relay_one_on, [4] relay_two_on,
                                  // [20:5] average_mm, [21] frame_good, [22] frame_bad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [16:0] cfg_wdata
);

  import ula_pkg::*;

  cfg_t       cfg_r;
  logic       a_valid_r;
  logic       a_kind_r;
  logic [7:0] a_byte_r;
  logic       a_advance;
  logic       out_valid_r;
  logic [2:0] out_stage_r;
  logic       out_relay1_r, out_relay2_r;
  logic [15:0] out_avg_r;
  logic       out_good_r, out_bad_r;
  parse_res_t pres;
  logic [15:0] average_nxt;
  stage_t     stage_nxt;
  logic       relay1, relay2;

  assign a_advance = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || a_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.warning_level_mm  <= 16'd600;
      cfg_r.danger_level_mm   <= 16'd400;
      cfg_r.critical_level_mm <= 16'd250;
      cfg_r.startup_hold_ms   <= 16'd10000;
      cfg_r.confirm_time_ms   <= 16'd2500;
      cfg_r.latch_hold_ms     <= 17'd60000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WARNING:  cfg_r.warning_level_mm  <= cfg_wdata[15:0];
        CFG_DANGER:   cfg_r.danger_level_mm   <= cfg_wdata[15:0];
        CFG_CRITICAL: cfg_r.critical_level_mm <= cfg_wdata[15:0];
        CFG_STARTUP:  cfg_r.startup_hold_ms   <= cfg_wdata[15:0];
        CFG_CONFIRM:  cfg_r.confirm_time_ms   <= cfg_wdata[15:0];
        CFG_LATCH:    cfg_r.latch_hold_ms     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_kind_r <= in_tuser;
      a_byte_r <= in_tdata;
    end
  end

  ula_parser #(
    .SAMPLE_COUNT (SAMPLE_COUNT)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (a_advance && !a_kind_r),
    .byte_value  (a_byte_r),
    .res         (pres),
    .average_nxt (average_nxt)
  );

  ula_grader u_grader (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (a_advance && a_kind_r),
    .average   (average_nxt),
    .cfg       (cfg_r),
    .stage_nxt (stage_nxt)
  );

  always_comb begin
    unique case (stage_nxt)
      STAGE_WARNING:  begin relay1 = 1'b1; relay2 = 1'b0; end
      STAGE_DANGER:   begin relay1 = 1'b0; relay2 = 1'b1; end
      STAGE_CRITICAL: begin relay1 = 1'b1; relay2 = 1'b1; end
      STAGE_LATCHED:  begin relay1 = 1'b1; relay2 = 1'b1; end
      default:        begin relay1 = 1'b0; relay2 = 1'b0; end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      out_stage_r  <= stage_nxt;
      out_relay1_r <= relay1;
      out_relay2_r <= relay2;
      out_avg_r    <= average_nxt;
      out_good_r   <= pres.frame_good;
      out_bad_r    <= pres.frame_bad;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_bad_r, out_good_r, out_avg_r,
                       out_relay2_r, out_relay1_r, out_stage_r};

  a_verdict_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_good_r && out_bad_r))
    else $error("frame_good and frame_bad both set");

  a_tick_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (a_advance && a_kind_r) |=> (out_valid_r && !out_good_r && !out_bad_r))
    else $error("tick transfer produced a frame verdict");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    a_advance |=> out_valid_r)
    else $error("processed item did not reach the result register");

  a_startup_relays_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stage_r == STAGE_STARTUP) |-> (!out_relay1_r && !out_relay2_r))
    else $error("relay driven during startup hold");

endmodule
